// File: rtl/sbch_pkg.sv
// Package for the square-root binned beam count histogram.
// Holds default parameters, result field widths and the controller/datapath structs.
// Depends on nothing; every other file of the block but sbch_div uses it.
package sbch_pkg;

    localparam int NUM_BINS   = 12;
    localparam int MAX_BEAMS  = 65536;
    localparam int COUNT_BITS = 16;

    // Fixed widths of the result fields.
    localparam int BEAM_TOTAL_W   = 17;
    localparam int SAMPLE_TOTAL_W = 32;
    localparam int MIN_W          = 16;
    localparam int MEDIAN_W       = 17;
    localparam int MAX_W          = 16;
    localparam int BIN_INDEX_W    = 4;
    localparam int BIN_BOUND_W    = 17;
    localparam int BIN_COUNT_W    = 17;

    // Values of record_kind.
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_BIN     = 1'b1;

    typedef struct packed {
        logic                      record_kind;
        logic                      is_last;
        logic [BEAM_TOTAL_W-1:0]   beam_total;
        logic [SAMPLE_TOTAL_W-1:0] sample_total;
        logic [MIN_W-1:0]          min_samples;
        logic [MEDIAN_W-1:0]       median_samples;
        logic [MAX_W-1:0]          max_samples;
        logic                      stats_valid;
        logic [BIN_INDEX_W-1:0]    bin_index;
        logic [BIN_BOUND_W-1:0]    bin_low;
        logic [BIN_BOUND_W-1:0]    bin_high;
        logic [BIN_COUNT_W-1:0]    bin_count;
    } sbch_rec_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // an input transaction is accepted this cycle
        logic setup_init;    // initialize threshold, median and read-address state
        logic acc;           // advance the square accumulator and start a bound division
        logic bnd_load;      // push the finished quotient into the bound lanes
        logic rd_en;         // read the next stored count
        logic scan_step;     // one step of the median scan
        logic med_start;     // start the median division
        logic med_capture;   // store the clamped median
        logic emit_bin;      // the result shown is a bin record
        logic bin_start;     // lower bound of the first bin is zero
        logic bin_next;      // a bin record was taken
        logic last_bin;      // the bin shown is the final one
        logic clear;         // end of the section
    } sbch_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_zero;
        logic div_busy;
        logic addr_last;
    } sbch_sts_t;

endpackage

// File: rtl/sbch_beam_if.sv
// Input channel of the histogram block: one beam count per transaction.
// Depends on sbch_pkg for the default count width.
interface sbch_beam_if #(
    parameter int COUNT_BITS = sbch_pkg::COUNT_BITS
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] beam_samples;
    logic                  last_beam;

    modport source (output valid, beam_samples, last_beam, input ready);
    modport sink   (input valid, beam_samples, last_beam, output ready);
endinterface

// File: rtl/sbch_report_if.sv
// Output channel of the histogram block: one summary or bin record per transaction.
// Depends on sbch_pkg for the field widths.
interface sbch_report_if;
    logic                                valid;
    logic                                ready;
    logic                                record_kind;
    logic                                is_last;
    logic [sbch_pkg::BEAM_TOTAL_W-1:0]   beam_total;
    logic [sbch_pkg::SAMPLE_TOTAL_W-1:0] sample_total;
    logic [sbch_pkg::MIN_W-1:0]          min_samples;
    logic [sbch_pkg::MEDIAN_W-1:0]       median_samples;
    logic [sbch_pkg::MAX_W-1:0]          max_samples;
    logic                                stats_valid;
    logic [sbch_pkg::BIN_INDEX_W-1:0]    bin_index;
    logic [sbch_pkg::BIN_BOUND_W-1:0]    bin_low;
    logic [sbch_pkg::BIN_BOUND_W-1:0]    bin_high;
    logic [sbch_pkg::BIN_COUNT_W-1:0]    bin_count;

    modport source (output valid, record_kind, is_last, beam_total, sample_total,
                    min_samples, median_samples, max_samples, stats_valid, bin_index,
                    bin_low, bin_high, bin_count, input ready);
    modport sink   (input valid, record_kind, is_last, beam_total, sample_total,
                    min_samples, median_samples, max_samples, stats_valid, bin_index,
                    bin_low, bin_high, bin_count, output ready);
endinterface

// File: rtl/sqrt_binned_count_histogram.sv
// Top level of the square-root binned beam count histogram.
// Depends on sbch_pkg, sbch_beam_if, sbch_report_if, sbch_ctrl and sbch_dp.
//
// The block takes one beam sample count per input transaction and stores it, keeping
// the beam count, the 32-bit wrapping sample sum, the minimum and the maximum. A
// transaction flagged last_beam closes the section. If the sample sum is zero the block
// returns one summary record with stats_valid low and is_last high. Otherwise it sorts
// every stored count into NUM_BINS bins spaced on a square-root scale, where bin b holds
// the counts that exceed exactly b of the bounds floor(i*i*(max+1)/NUM_BINS^2) for
// i = 1..NUM_BINS-1, and returns one summary record with the median estimate followed
// by NUM_BINS bin records, the last one marked is_last. Beams beyond MAX_BEAMS are
// dropped, but a last flag on such a beam still closes the section. Loading accepts one
// beam per cycle. After the last beam the block checks the sum, then runs NUM_BINS-1
// bound divisions on the shared divider, which multiplies by a fixed reciprocal of
// NUM_BINS^2, first taking the numerator and then forming the product. It then reads
// the N stored counts through the single read port of the count store, runs the median
// scan over the NUM_BINS bin tallies and the median division; the NUM_BINS+1 records
// then leave at one per cycle while the sink takes them. No new beam is taken until the
// last record of the section has been delivered. The count store needs no clearing
// pass, since only entries written in the current section are read.
module sqrt_binned_count_histogram #(
    parameter int NUM_BINS   = sbch_pkg::NUM_BINS,
    parameter int MAX_BEAMS  = sbch_pkg::MAX_BEAMS,
    parameter int COUNT_BITS = sbch_pkg::COUNT_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    sbch_beam_if.sink     beam,
    sbch_report_if.source report
);

    sbch_pkg::sbch_cmd_t         cmd;
    sbch_pkg::sbch_sts_t         sts;
    sbch_pkg::sbch_rec_t         rec;
    logic [$clog2(NUM_BINS)-1:0] bin_idx;

    // The controller owns the handshakes and the loop counter; the datapath owns
    // the data and reports back only the few flags the sequencing depends on.
    sbch_ctrl #(
        .NUM_BINS (NUM_BINS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (beam.valid),
        .in_last   (beam.last_beam),
        .in_ready  (beam.ready),
        .out_valid (report.valid),
        .out_ready (report.ready),
        .sts       (sts),
        .cmd       (cmd),
        .bin_idx   (bin_idx)
    );

    sbch_dp #(
        .NUM_BINS   (NUM_BINS),
        .MAX_BEAMS  (MAX_BEAMS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .beam_samples (beam.beam_samples),
        .cmd          (cmd),
        .bin_idx      (bin_idx),
        .sts          (sts),
        .rec          (rec)
    );

    // The record is held steady by the datapath registers for as long as it is offered.
    assign report.record_kind    = rec.record_kind;
    assign report.is_last        = rec.is_last;
    assign report.beam_total     = rec.beam_total;
    assign report.sample_total   = rec.sample_total;
    assign report.min_samples    = rec.min_samples;
    assign report.median_samples = rec.median_samples;
    assign report.max_samples    = rec.max_samples;
    assign report.stats_valid    = rec.stats_valid;
    assign report.bin_index      = rec.bin_index;
    assign report.bin_low        = rec.bin_low;
    assign report.bin_high       = rec.bin_high;
    assign report.bin_count      = rec.bin_count;

endmodule

// File: rtl/sbch_ctrl.sv
// Controller of the histogram block: sequences loading, bound setup, the bin pass,
// the median scan and the result records. Depends on sbch_pkg for the command structs.
module sbch_ctrl #(
    parameter int NUM_BINS = sbch_pkg::NUM_BINS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_last,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  sbch_pkg::sbch_sts_t           sts,
    output sbch_pkg::sbch_cmd_t           cmd,
    output logic [$clog2(NUM_BINS)-1:0]   bin_idx
);

    localparam int IDX_W = $clog2(NUM_BINS);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_BINS - 1);
    localparam logic [IDX_W-1:0] IDX_BOUND = IDX_W'(NUM_BINS - 2);

    typedef enum logic [10:0] {
        ST_LOAD    = 11'b000_0000_0001,
        ST_CHECK   = 11'b000_0000_0010,
        ST_ACC     = 11'b000_0000_0100,
        ST_DIV     = 11'b000_0000_1000,
        ST_CLASS   = 11'b000_0001_0000,
        ST_DRAIN   = 11'b000_0010_0000,
        ST_SCAN    = 11'b000_0100_0000,
        ST_MSTART  = 11'b000_1000_0000,
        ST_MWAIT   = 11'b001_0000_0000,
        ST_SUMMARY = 11'b010_0000_0000,
        ST_BINS    = 11'b100_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    assign bin_idx   = idx_reg;
    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_SUMMARY) || (state_reg == ST_BINS);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.load   = in_valid && in_ready;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                idx_next = '0;
                if (sts.sum_zero)
                begin
                    state_next = ST_SUMMARY;
                end
                else
                begin
                    cmd.setup_init = 1'b1;
                    state_next     = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    cmd.bnd_load = 1'b1;
                    if (idx_reg == IDX_BOUND)
                    begin
                        idx_next   = '0;
                        state_next = ST_CLASS;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_ACC;
                    end
                end
            end
            ST_CLASS:
            begin
                cmd.rd_en = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_MSTART;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_MSTART:
            begin
                cmd.med_start = 1'b1;
                state_next    = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.med_capture = 1'b1;
                    state_next      = ST_SUMMARY;
                end
            end
            ST_SUMMARY:
            begin
                if (out_ready)
                begin
                    if (sts.sum_zero)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.bin_start = 1'b1;
                        idx_next      = '0;
                        state_next    = ST_BINS;
                    end
                end
            end
            ST_BINS:
            begin
                cmd.emit_bin = 1'b1;
                cmd.last_bin = (idx_reg == IDX_LAST);
                if (out_ready)
                begin
                    cmd.bin_next = 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Loading and result delivery never overlap.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is offered");

    // A finished bound division always moves on to the next bound or to the bin pass.
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !sts.div_busy) |=>
        (state_reg == ST_ACC || state_reg == ST_CLASS))
        else $error("bound division did not hand over");

    // A stalled bin record keeps its index.
    a_bin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BINS && !out_ready) |=> (state_reg == ST_BINS && $stable(idx_reg)))
        else $error("bin record changed while stalled");

    // A section is closed only by an accepted last beam.
    a_check_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> $past(state_reg == ST_LOAD && in_valid && in_last))
        else $error("section closed without a last beam");
`endif

endmodule

// File: rtl/sbch_div.sv
// Divider by a fixed divisor, built as a multiplication by its rounded-up reciprocal.
// Standalone unit used by the histogram datapath; no package dependency.
module sbch_div #(
    parameter int NUM_W   = 32,
    parameter int QUO_W   = 16,
    parameter int DIVISOR = 144
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    output logic             busy,
    output logic [QUO_W-1:0] quotient
);

    // With SHIFT = NUM_W + clog2(DIVISOR) the rounding error of the reciprocal stays
    // below one part in DIVISOR for every NUM_W-bit numerator, so the quotient is exact.
    localparam int SHIFT   = NUM_W + $clog2(DIVISOR);
    localparam int RECIP_W = NUM_W + 1;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic              busy_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [PROD_W-1:0] prod;

    // The numerator is captured first; the product is formed and kept in the cycle after.
    assign prod     = PROD_W'(num_reg) * PROD_W'(RECIP);
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
        end
        if (busy_reg)
        begin
            quo_reg <= prod[SHIFT +: QUO_W];
        end
    end

endmodule

// File: rtl/sbch_dp.sv
// Datapath of the histogram block: count store, running statistics, bound lanes,
// bin tallies, median accumulators and the shared divider. Depends on sbch_pkg, sbch_div.
module sbch_dp #(
    parameter int NUM_BINS   = sbch_pkg::NUM_BINS,
    parameter int MAX_BEAMS  = sbch_pkg::MAX_BEAMS,
    parameter int COUNT_BITS = sbch_pkg::COUNT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [COUNT_BITS-1:0]        beam_samples,
    input  sbch_pkg::sbch_cmd_t          cmd,
    input  logic [$clog2(NUM_BINS)-1:0]  bin_idx,
    output sbch_pkg::sbch_sts_t          sts,
    output sbch_pkg::sbch_rec_t          rec
);

    localparam int NB2    = NUM_BINS * NUM_BINS;
    localparam int MAXP_W = COUNT_BITS + 1;
    localparam int TW     = $clog2(NB2) + MAXP_W;
    localparam int MW     = TW + 3;
    localparam int QW     = MAXP_W + 2;
    localparam int BEAM_W = $clog2(MAX_BEAMS + 1);
    localparam int ADDR_W = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
    localparam int IDX_W  = $clog2(NUM_BINS);

    logic [COUNT_BITS-1:0] mem [MAX_BEAMS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic [BEAM_W-1:0]     rd_addr_reg;

    logic [BEAM_W-1:0]     beams_reg;
    logic [31:0]           sum_reg;
    logic [COUNT_BITS-1:0] min_reg;
    logic [COUNT_BITS-1:0] max_reg;

    logic [TW-1:0]         thr_reg;
    logic [TW-1:0]         step_reg;
    logic [TW-1:0]         thr_sum;
    logic [MAXP_W-1:0]     bnd_reg [NUM_BINS-1];
    logic [BEAM_W-1:0]     tally_reg [NUM_BINS];

    logic [MW-1:0]         med_acc_reg;
    logic [MW-1:0]         med_inc_reg;
    logic [BEAM_W-1:0]     cnt_reg;
    logic [MAXP_W-1:0]     med_reg;
    logic [MAXP_W-1:0]     lo_reg;

    logic [MAXP_W-1:0]     maxp;
    logic                  store_en;
    logic [NUM_BINS-2:0]   gt;
    logic [NUM_BINS-1:0]   hit;
    logic [MW-1:0]         div_numer;
    logic                  div_busy;
    logic [QW-1:0]         quotient;
    logic [MAXP_W-1:0]     med_q;
    logic [MAXP_W-1:0]     bin_hi;

    assign maxp     = {1'b0, max_reg} + MAXP_W'(1);
    assign store_en = cmd.load && (beams_reg < BEAM_W'(MAX_BEAMS));
    assign thr_sum  = thr_reg + step_reg;
    assign med_q    = quotient[QW-1:2];

    assign sts.sum_zero  = (sum_reg == 32'd0);
    assign sts.div_busy  = div_busy;
    assign sts.addr_last = (rd_addr_reg == beams_reg - BEAM_W'(1));

    // Count store: one write port while loading, one registered read port in the bin pass.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[beams_reg[ADDR_W-1:0]] <= beam_samples;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beams_reg    <= '0;
            sum_reg      <= '0;
            min_reg      <= '1;
            max_reg      <= '0;
            rd_addr_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.clear)
            begin
                beams_reg   <= '0;
                sum_reg     <= '0;
                min_reg     <= '1;
                max_reg     <= '0;
                rd_addr_reg <= '0;
            end
            else
            begin
                if (store_en)
                begin
                    beams_reg <= beams_reg + BEAM_W'(1);
                    sum_reg   <= sum_reg + 32'(beam_samples);
                    if (beam_samples < min_reg)
                    begin
                        min_reg <= beam_samples;
                    end
                    if (beam_samples > max_reg)
                    begin
                        max_reg <= beam_samples;
                    end
                end
                if (cmd.setup_init)
                begin
                    rd_addr_reg <= '0;
                end
                else if (cmd.rd_en)
                begin
                    rd_addr_reg <= rd_addr_reg + BEAM_W'(1);
                end
            end
        end
    end

    // i*i*(max+1) built by adding odd multiples of max+1; (2k-1)^2*(max+1) by adding multiples of 8*(max+1).
    always_ff @(posedge clk)
    begin
        if (cmd.setup_init)
        begin
            thr_reg     <= '0;
            step_reg    <= TW'(maxp);
            med_acc_reg <= MW'(maxp);
            med_inc_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.acc)
            begin
                thr_reg  <= thr_sum;
                step_reg <= step_reg + TW'({maxp, 1'b0});
            end
            if (cmd.scan_step && ({cnt_reg, 1'b0} < {1'b0, beams_reg}))
            begin
                cnt_reg     <= cnt_reg + tally_reg[0];
                med_acc_reg <= med_acc_reg + med_inc_reg;
                med_inc_reg <= med_inc_reg + MW'({maxp, 3'b000});
            end
        end
        if (cmd.med_capture)
        begin
            med_reg <= (med_q < {1'b0, min_reg}) ? {1'b0, min_reg} : med_q;
        end
        if (cmd.bin_start)
        begin
            lo_reg <= '0;
        end
        else if (cmd.bin_next)
        begin
            lo_reg <= bin_hi;
        end
    end

    // Bound lanes: filled from the top during setup, shifted down while bins go out.
    always_ff @(posedge clk)
    begin
        if (cmd.bnd_load || cmd.bin_next)
        begin
            for (int j = 0; j < NUM_BINS - 2; j++)
            begin
                bnd_reg[j] <= bnd_reg[j+1];
            end
            bnd_reg[NUM_BINS-2] <= cmd.bnd_load ? quotient[MAXP_W-1:0] : bnd_reg[0];
        end
    end

    // A count exceeds a bound exactly when NUM_BINS^2 * count exceeds i*i*(max+1);
    // the bounds rise with i, so the compares form a thermometer code.
    always_comb
    begin
        for (int j = 0; j < NUM_BINS - 1; j++)
        begin
            gt[j] = ({1'b0, rd_data_reg} > bnd_reg[j]);
        end
        hit[0] = !gt[0];
        for (int j = 1; j < NUM_BINS - 1; j++)
        begin
            hit[j] = gt[j-1] && !gt[j];
        end
        hit[NUM_BINS-1] = gt[NUM_BINS-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_BINS; j++)
            begin
                tally_reg[j] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int j = 0; j < NUM_BINS; j++)
            begin
                tally_reg[j] <= '0;
            end
        end
        else if (cmd.scan_step || cmd.bin_next)
        begin
            for (int j = 0; j < NUM_BINS - 1; j++)
            begin
                tally_reg[j] <= tally_reg[j+1];
            end
            tally_reg[NUM_BINS-1] <= tally_reg[0];
        end
        else if (rd_valid_reg)
        begin
            for (int j = 0; j < NUM_BINS; j++)
            begin
                if (hit[j])
                begin
                    tally_reg[j] <= tally_reg[j] + BEAM_W'(1);
                end
            end
        end
    end

    // The median divides by 4*NUM_BINS^2: divide by NUM_BINS^2 and drop two bits.
    assign div_numer = cmd.med_start ? (med_acc_reg + MW'(2 * NB2)) : MW'(thr_sum);

    sbch_div #(
        .NUM_W   (MW),
        .QUO_W   (QW),
        .DIVISOR (NB2)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.acc || cmd.med_start),
        .numer    (div_numer),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign bin_hi = cmd.last_bin ? maxp : bnd_reg[0];

    always_comb
    begin
        rec = '0;
        if (cmd.emit_bin)
        begin
            rec.record_kind = sbch_pkg::KIND_BIN;
            rec.is_last     = cmd.last_bin;
            rec.stats_valid = 1'b1;
            rec.bin_index   = sbch_pkg::BIN_INDEX_W'(bin_idx);
            rec.bin_low     = sbch_pkg::BIN_BOUND_W'(lo_reg);
            rec.bin_high    = sbch_pkg::BIN_BOUND_W'(bin_hi);
            rec.bin_count   = sbch_pkg::BIN_COUNT_W'(tally_reg[0]);
        end
        else
        begin
            rec.record_kind  = sbch_pkg::KIND_SUMMARY;
            rec.is_last      = sts.sum_zero;
            rec.stats_valid  = !sts.sum_zero;
            rec.beam_total   = sbch_pkg::BEAM_TOTAL_W'(beams_reg);
            rec.sample_total = sum_reg;
            if (!sts.sum_zero)
            begin
                rec.min_samples    = sbch_pkg::MIN_W'(min_reg);
                rec.median_samples = sbch_pkg::MEDIAN_W'(med_reg);
                rec.max_samples    = sbch_pkg::MAX_W'(max_reg);
            end
        end
    end

endmodule

// File: tb/sbch_report_checker.sv
`timescale 1ns / 100ps
// Result checker for the square-root binned beam count histogram.
// Depends on sbch_pkg, sbch_beam_if and sbch_report_if; it only watches the channels.
module sbch_report_checker
    import sbch_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sbch_beam_if        beam,
    sbch_report_if      report,
    output int unsigned failures,
    output int unsigned pending
);

    // Section state kept alongside the block.
    logic [COUNT_BITS-1:0]   held_counts[$];
    logic [BEAM_TOTAL_W-1:0] beams_held;
    logic [SAMPLE_TOTAL_W-1:0] sample_sum;
    logic [MIN_W-1:0]        low_count;
    logic [MAX_W-1:0]        high_count;

    sbch_rec_t   awaited_records[$];
    int unsigned shown;

    function automatic void restart_section();
        held_counts.delete();
        beams_held = '0;
        sample_sum = '0;
        low_count  = '1;
        high_count = '0;
    endfunction

    // Builds the summary and, when the sum is nonzero, the bin records of a section.
    function automatic void close_section();
        sbch_rec_t       rec;
        longint unsigned span, sq_bins, v, i, k, seen, med, lo, hi, bin;
        longint unsigned tally[NUM_BINS];
        rec              = '0;
        rec.record_kind  = KIND_SUMMARY;
        rec.beam_total   = beams_held;
        rec.sample_total = sample_sum;
        if (sample_sum == 0)
        begin
            rec.is_last = 1'b1;
            awaited_records.push_back(rec);
            restart_section();
            return;
        end
        span    = 64'(high_count) + 64'd1;
        sq_bins = NUM_BINS * NUM_BINS;
        foreach (tally[b])
            tally[b] = 0;
        // A count lands in the bin numbered by how many square-root bounds it exceeds.
        foreach (held_counts[j])
        begin
            v   = held_counts[j];
            bin = 0;
            for (i = 1; i < NUM_BINS; i++)
                if (sq_bins * v > i * i * span)
                    bin++;
            tally[bin]++;
        end
        seen = 0;
        k    = 0;
        while (k < NUM_BINS && (seen << 1) < beams_held)
        begin
            seen += tally[k];
            k++;
        end
        med = ((2 * k - 1) * (2 * k - 1) * span * 2 + 4 * sq_bins) / (8 * sq_bins);
        if (med < low_count)
            med = low_count;
        rec.min_samples    = low_count;
        rec.median_samples = med[MEDIAN_W-1:0];
        rec.max_samples    = high_count;
        rec.stats_valid    = 1'b1;
        awaited_records.push_back(rec);
        hi = 0;
        for (i = 0; i < NUM_BINS; i++)
        begin
            lo              = hi;
            hi              = (i + 1) * (i + 1) * span / sq_bins;
            rec             = '0;
            rec.record_kind = KIND_BIN;
            rec.is_last     = (i == NUM_BINS - 1);
            rec.stats_valid = 1'b1;
            rec.bin_index   = i[BIN_INDEX_W-1:0];
            rec.bin_low     = lo[BIN_BOUND_W-1:0];
            rec.bin_high    = hi[BIN_BOUND_W-1:0];
            rec.bin_count   = tally[i][BIN_COUNT_W-1:0];
            awaited_records.push_back(rec);
        end
        restart_section();
    endfunction

    function automatic void absorb_beam(logic [COUNT_BITS-1:0] n, logic closes);
        // Beams past capacity are dropped, but their last flag still counts.
        if (beams_held < MAX_BEAMS)
        begin
            held_counts.push_back(n);
            beams_held++;
            sample_sum += n;
            if (n < low_count)
                low_count = n;
            if (n > high_count)
                high_count = n;
        end
        if (closes)
            close_section();
    endfunction

    function automatic int unsigned field_differs(string fname, logic [31:0] want,
                                                  logic [31:0] got);
        if (got === want)
            return 0;
        if (shown < 60)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            shown++;
        end
        return 1;
    endfunction

    function automatic int unsigned compare_record(sbch_rec_t want, sbch_rec_t got);
        int unsigned errs;
        errs = 0;
        errs += field_differs("record_kind", want.record_kind, got.record_kind);
        errs += field_differs("is_last", want.is_last, got.is_last);
        errs += field_differs("beam_total", want.beam_total, got.beam_total);
        errs += field_differs("sample_total", want.sample_total, got.sample_total);
        errs += field_differs("min_samples", want.min_samples, got.min_samples);
        errs += field_differs("median_samples", want.median_samples, got.median_samples);
        errs += field_differs("max_samples", want.max_samples, got.max_samples);
        errs += field_differs("stats_valid", want.stats_valid, got.stats_valid);
        errs += field_differs("bin_index", want.bin_index, got.bin_index);
        errs += field_differs("bin_low", want.bin_low, got.bin_low);
        errs += field_differs("bin_high", want.bin_high, got.bin_high);
        errs += field_differs("bin_count", want.bin_count, got.bin_count);
        return errs;
    endfunction

    always @(posedge clk)
    begin
        int unsigned bad;
        sbch_rec_t   got;
        bad = 0;
        if (!rst_n)
        begin
            restart_section();
            awaited_records.delete();
        end
        else
        begin
            if (report.valid && report.ready)
            begin
                got.record_kind    = report.record_kind;
                got.is_last        = report.is_last;
                got.beam_total     = report.beam_total;
                got.sample_total   = report.sample_total;
                got.min_samples    = report.min_samples;
                got.median_samples = report.median_samples;
                got.max_samples    = report.max_samples;
                got.stats_valid    = report.stats_valid;
                got.bin_index      = report.bin_index;
                got.bin_low        = report.bin_low;
                got.bin_high       = report.bin_high;
                got.bin_count      = report.bin_count;
                if (awaited_records.size() == 0)
                begin
                    bad++;
                    if (shown < 60)
                    begin
                        $display("%0t: unexpected result, expected none, actual kind %0d bin %0d",
                                 $time, got.record_kind, got.bin_index);
                        shown++;
                    end
                end
                else
                    bad += compare_record(awaited_records.pop_front(), got);
            end
            if (beam.valid && beam.ready)
                absorb_beam(beam.beam_samples, beam.last_beam);
        end
        failures <= failures + bad;
        pending  <= awaited_records.size();
    end

endmodule

// File: tb/tb_sqrt_binned_count_histogram.sv
`timescale 1ns / 100ps
// Testbench top for the square-root binned beam count histogram.
// Depends on sbch_pkg, both channel interfaces, the block and sbch_report_checker.
module tb_sqrt_binned_count_histogram;
    import sbch_pkg::*;

    // Value shapes used for the counts of one random section.
    typedef enum int {MIX_FULL, MIX_TINY, MIX_HIGH, MIX_SPARSE, MIX_ZERO, MIX_CLUSTER}
        count_mix_t;

    // Styles of backpressure the receiver rotates through.
    typedef enum int {READY_ALWAYS, READY_COIN, READY_EVERY_THIRD, READY_MOSTLY}
        stall_style_t;

    logic        clk;
    logic        rst_n;
    int unsigned failures;
    int unsigned pending;

    // Sender bookkeeping: beams left in the current burst and whether valid is
    // currently driven high.
    int unsigned burst_left;
    bit          offering;

    // Set by the stimulus to ask the receiver for one long hold-off.
    bit          hold_off_armed;

    sbch_beam_if   beam_ch ();
    sbch_report_if report_ch ();

    sqrt_binned_count_histogram DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .beam   (beam_ch),
        .report (report_ch)
    );

    // The checker follows every transaction on both channels, predicts the
    // records of each section and compares them in order.
    sbch_report_checker checker_inst (
        .clk      (clk),
        .rst_n    (rst_n),
        .beam     (beam_ch),
        .report   (report_ch),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog. Even with every beam closing its own section under the heaviest
    // stalls the run ends before the limit below is reached, so that limit
    // leaves a wide margin.
    initial
    begin
        #10_000_000;
        $display("sqrt_binned_count_histogram test failed");
        $finish;
    end

    // Offers one beam and returns at the edge where it was accepted. Between
    // bursts the sender drops valid for a random number of cycles; a zero gap
    // keeps valid high so that back-to-back transactions are exercised too.
    task automatic send_beam(input logic [COUNT_BITS-1:0] n, input logic closes);
        int unsigned gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(0, 3);
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(1, 8);
            if (gap != 0)
            begin
                if (offering)
                begin
                    beam_ch.valid <= 1'b0;
                    offering = 1'b0;
                end
                repeat (gap) @(posedge clk);
            end
        end
        beam_ch.valid        <= 1'b1;
        beam_ch.beam_samples <= n;
        beam_ch.last_beam    <= closes;
        offering = 1'b1;
        @(posedge clk);
        while (!beam_ch.ready)
            @(posedge clk);
        if (burst_left != 0)
            burst_left--;
    endtask

    // Stops offering and waits until the checker has seen every awaited record.
    // The checker publishes its count through a register, hence the first edge.
    task automatic wait_drained();
        if (offering)
        begin
            beam_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Receiver. It cycles through several backpressure styles, including a
    // stretch with ready held high, so stalls land on every record position.
    // Once armed, it waits for a record to show up and then refuses it until
    // its hold-off count runs out; the sender keeps offering meanwhile, so the
    // block has to hold its input off until the records drain.
    initial
    begin : receiver
        int unsigned  cyc;
        int unsigned  hold_left;
        stall_style_t style;
        cyc       = 0;
        hold_left = 0;
        report_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            style = stall_style_t'((cyc / 48) % 4);
            if (hold_left != 0)
            begin
                hold_left--;
                report_ch.ready <= 1'b0;
            end
            else if (hold_off_armed && report_ch.valid)
            begin
                hold_off_armed = 1'b0;
                hold_left      = 600;
                report_ch.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    READY_ALWAYS:      report_ch.ready <= 1'b1;
                    READY_COIN:        report_ch.ready <= ($urandom_range(0, 1) == 1);
                    READY_EVERY_THIRD: report_ch.ready <= (cyc % 3 == 0);
                    default:           report_ch.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int unsigned          random_beams;
        int unsigned          len;
        int unsigned          center;
        count_mix_t           mix;
        logic [COUNT_BITS-1:0] n;

        burst_left     = 0;
        offering       = 1'b0;
        hold_off_armed = 1'b0;
        rst_n                <= 1'b0;
        beam_ch.valid        <= 1'b0;
        beam_ch.beam_samples <= '0;
        beam_ch.last_beam    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sections. A lone zero gives a zero-sum summary with no bins.
        send_beam(16'd0, 1'b1);
        // A lone full-scale count: every bound stretches to the top of the range.
        send_beam(16'd65535, 1'b1);
        // Extremes mixed with middle values spread over several bins.
        send_beam(16'd0, 1'b0);
        send_beam(16'd65535, 1'b0);
        send_beam(16'd1, 1'b0);
        send_beam(16'd32768, 1'b0);
        send_beam(16'd100, 1'b1);
        // Several zeros: zero sum again, with a beam total above one.
        send_beam(16'd0, 1'b0);
        send_beam(16'd0, 1'b0);
        send_beam(16'd0, 1'b1);
        // A single count of one: the smallest nonzero maximum.
        send_beam(16'd1, 1'b1);
        // Identical full-scale counts: the estimated median falls below the
        // minimum and has to be raised to it.
        send_beam(16'd65535, 1'b0);
        send_beam(16'd65535, 1'b0);
        send_beam(16'd65535, 1'b0);
        send_beam(16'd65535, 1'b1);
        // Small scattered counts, then alternating bit patterns.
        send_beam(16'd7, 1'b0);
        send_beam(16'd3, 1'b0);
        send_beam(16'd12, 1'b0);
        send_beam(16'd5, 1'b0);
        send_beam(16'd9, 1'b0);
        send_beam(16'd0, 1'b1);
        send_beam(16'h5555, 1'b0);
        send_beam(16'hAAAA, 1'b1);

        // Sender pause: nothing more is offered until every record has come back.
        wait_drained();

        // Random sections. Most are short, a few are longer, and each draws its
        // counts from one shape so that bins fill unevenly. The first record
        // of this phase triggers the receiver's long hold-off.
        hold_off_armed = 1'b1;
        random_beams   = 0;
        while (random_beams < 500)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(17, 80);
            else
                len = $urandom_range(1, 16);
            mix    = count_mix_t'($urandom_range(0, 5));
            center = $urandom_range(64, 65000);
            for (int j = 0; j < len; j++)
            begin
                case (mix)
                    MIX_FULL:   n = COUNT_BITS'($urandom_range(0, 65535));
                    MIX_TINY:   n = COUNT_BITS'($urandom_range(0, 15));
                    MIX_HIGH:   n = COUNT_BITS'($urandom_range(61440, 65535));
                    MIX_SPARSE:
                    begin
                        if ($urandom_range(0, 3) == 0)
                            n = COUNT_BITS'($urandom_range(1, 65535));
                        else
                            n = '0;
                    end
                    MIX_ZERO:   n = '0;
                    default:    n = COUNT_BITS'(center + $urandom_range(0, 63));
                endcase
                send_beam(n, j == len - 1);
            end
            random_beams += len;
            // Now and then let the block run dry between sections.
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        // Wait for the last records, then leave room for anything spurious.
        wait_drained();
        repeat (400) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("sqrt_binned_count_histogram test passed");
        else
            $display("sqrt_binned_count_histogram test failed");
        $finish;
    end

endmodule
